@@ rtl/orr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ordered route table lookup.
// No dependencies; imported by every module of the block.
package orr_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int IFACE_COUNT       = 16;

   localparam int ADDR_W  = 32;
   localparam int IFACE_W = 4;
   localparam int STAT_W  = 3;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_DEL    = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_RSVD   = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_EXISTS    = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_NO_ROUTE  = 3'd4
   } stat_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // one stored route
   typedef struct packed {
      logic [ADDR_W-1:0]  dest;
      logic [ADDR_W-1:0]  mask;
      logic [ADDR_W-1:0]  gateway;
      logic               host;
      logic               via;
      logic               up;
      logic [IFACE_W-1:0] iface;
   } entry_type;

   // captured request
   typedef struct packed {
      cmd_type    cmd;
      entry_type  ent;
   } req_type;

   // table update strobes from the controller to every cell
   typedef struct packed {
      logic add_commit;
      logic del_commit;
   } ctl_type;

   // per-cell lookup answer
   typedef struct packed {
      logic               hit;
      logic [ADDR_W-1:0]  hop;
      logic [IFACE_W-1:0] iface;
   } ans_type;

endpackage

@@ rtl/orr_cell.sv @@
`timescale 1ns / 1ps
// One table slot: stored route, valid bit, compares and neighbor shift.
// Depends on orr_pkg.
module orr_cell (
   input  logic                clock,
   input  logic                reset,
   input  orr_pkg::req_type    req,
   input  orr_pkg::ctl_type    ctl,
   input  logic                prev_valid,
   input  logic                prefix_in,
   input  logic                next_valid,
   input  orr_pkg::entry_type  next_entry,
   output logic                valid,
   output orr_pkg::entry_type  entry,
   output logic                dest_eq,
   output logic                prefix_out,
   output orr_pkg::ans_type    ans
);
   import orr_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      shift, fill, net_eq, def_rt;

   assign dest_eq    = valid_ff && (req.ent.dest == entry_ff.dest);
   assign prefix_out = prefix_in || dest_eq;

   // delete: this slot and all later ones pull from the right neighbor
   assign shift = ctl.del_commit && valid_ff && prefix_out;
   // add: first empty slot takes the new route
   assign fill  = ctl.add_commit && !valid_ff && prev_valid;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (shift) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end else if (fill) begin
         valid_in = 1'b1;
         entry_in = req.ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign net_eq = (req.ent.dest & entry_ff.mask) == entry_ff.dest;
   assign def_rt = entry_ff.dest == '0;

   always_comb begin
      ans.iface = entry_ff.iface;
      ans.hop   = entry_ff.gateway;
      ans.hit   = 1'b0;
      if (entry_ff.host) begin
         ans.hit = valid_ff && (req.ent.dest == entry_ff.dest);
      end else if (net_eq) begin
         ans.hit = valid_ff;
         ans.hop = req.ent.dest;
      end else begin
         ans.hit = valid_ff && def_rt;
      end
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

@@ rtl/orr_pick.sv @@
`timescale 1ns / 1ps
// First-match select over the per-cell lookup answers, lowest slot wins.
// Depends on orr_pkg.
module orr_pick #(
   parameter int TABLE_ENTRIES = orr_pkg::TABLE_ENTRIES_DEF
) (
   input  orr_pkg::ans_type ans [TABLE_ENTRIES],
   output orr_pkg::ans_type pick
);
   import orr_pkg::*;

   always_comb begin
      pick = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (ans[i].hit) begin
            pick = ans[i];
         end
      end
   end

endmodule

@@ rtl/ordered_route_table_lookup.sv @@
`timescale 1ns / 1ps
// Ordered IPv4 route table: add, delete with compaction, first-match lookup.
// Depends on orr_pkg, orr_cell and orr_pick.
//
//   channel | direction | ports                                          | handshake
//   req     | in        | command, dest_addr, net_mask, gateway_addr,    | req_valid/req_ready
//           |           | host/up/via_gateway flags, iface_id            |
//   rsp     | out       | status, next_hop, out_iface                    | rsp_valid/rsp_ready
//
// The accept edge captures the request; then in the commit cycle every cell
// compares against it, the first-match pick resolves, the table updates and
// the result register loads. The row of cells does all compares side by
// side; a delete shifts the tail left by one slot at once.
// The next request is taken while a finished result still waits in rsp.
// A result that is not taken stalls the commit cycle, and with it the intake.
// Synchronous active-high reset empties the table (valid bits only).
module ordered_route_table_lookup #(
   parameter int TABLE_ENTRIES = orr_pkg::TABLE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_dest_addr,
   input  logic [31:0] req_net_mask,
   input  logic [31:0] req_gateway_addr,
   input  logic        req_host_flag,
   input  logic        req_up_flag,
   input  logic        req_via_gateway_flag,
   input  logic [3:0]  req_iface_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_next_hop,
   output logic [3:0]  rsp_out_iface
);
   import orr_pkg::*;

   state_type state_ff, state_in;
   req_type   req_ff;
   ctl_type   ctl;

   logic        rsp_valid_ff, rsp_valid_in;
   stat_type    status_ff, status_in;
   logic [31:0] hop_ff, hop_in;
   logic [3:0]  iface_ff, iface_in;

   logic out_free, commit, dup, full, iface_ok;

   logic [TABLE_ENTRIES-1:0] valid_vec;
   logic [TABLE_ENTRIES-1:0] eq_vec;
   logic [TABLE_ENTRIES:0]   prefix;
   entry_type                entry_arr [TABLE_ENTRIES];
   ans_type                  ans_arr   [TABLE_ENTRIES];
   ans_type                  pick;

   // output register frees up this cycle if empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == ST_EXEC) && out_free;

   // ---------------- control FSM ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: req_ready = 1'b0;
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture (payload, no reset)
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.cmd           <= cmd_type'(req_command);
         req_ff.ent.dest      <= req_dest_addr;
         req_ff.ent.mask      <= req_net_mask;
         req_ff.ent.gateway   <= req_gateway_addr;
         req_ff.ent.host      <= req_host_flag;
         req_ff.ent.via       <= req_via_gateway_flag;
         req_ff.ent.up        <= req_up_flag;
         req_ff.ent.iface     <= req_iface_id;
      end
   end

   // ---------------- cell row ----------------
   assign prefix[0] = 1'b0;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      logic      prev_v, next_v;
      entry_type next_e;

      if (i == 0) begin : g_first
         assign prev_v = 1'b1;
      end else begin : g_mid
         assign prev_v = valid_vec[i-1];
      end

      if (i == TABLE_ENTRIES - 1) begin : g_last
         assign next_v = 1'b0;
         assign next_e = entry_arr[i];
      end else begin : g_inner
         assign next_v = valid_vec[i+1];
         assign next_e = entry_arr[i+1];
      end

      orr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .req        (req_ff),
         .ctl        (ctl),
         .prev_valid (prev_v),
         .prefix_in  (prefix[i]),
         .next_valid (next_v),
         .next_entry (next_e),
         .valid      (valid_vec[i]),
         .entry      (entry_arr[i]),
         .dest_eq    (eq_vec[i]),
         .prefix_out (prefix[i+1]),
         .ans        (ans_arr[i])
      );
   end

   orr_pick #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_pick (
      .ans  (ans_arr),
      .pick (pick)
   );

   assign dup      = prefix[TABLE_ENTRIES];     // some valid slot holds this destination
   assign full     = valid_vec[TABLE_ENTRIES-1];
   assign iface_ok = 32'(pick.iface) < 32'(IFACE_COUNT);

   // duplicate check comes before the full check
   assign ctl.add_commit = commit && (req_ff.cmd == CMD_ADD) && !dup && !full;
   assign ctl.del_commit = commit && (req_ff.cmd == CMD_DEL) && dup;

   // ---------------- result ----------------
   always_comb begin
      status_in = STAT_OK;
      hop_in    = '0;
      iface_in  = '0;
      unique case (req_ff.cmd)
         CMD_ADD: begin
            if (dup) begin
               status_in = STAT_EXISTS;
            end else if (full) begin
               status_in = STAT_FULL;
            end
         end
         CMD_DEL: begin
            if (!dup) begin
               status_in = STAT_NOT_FOUND;
            end
         end
         CMD_LOOKUP: begin
            // a match on an interface beyond the installed ones counts as no route
            if (pick.hit && iface_ok) begin
               hop_in   = pick.hop;
               iface_in = pick.iface;
            end else begin
               status_in = STAT_NO_ROUTE;
            end
         end
         CMD_RSVD: begin
            status_in = STAT_OK;
         end
         default: status_in = STAT_OK;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff <= status_in;
         hop_ff    <= hop_in;
         iface_ff  <= iface_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_next_hop  = hop_ff;
   assign rsp_out_iface = iface_ff;

   // ---------------- assertions ----------------
   // valid slots always form a prefix of the row
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("valid slots not contiguous");

   // destinations are unique, so at most one slot matches
   a_unique_dest: assert property (@(posedge clock) disable iff (reset)
      $onehot0(eq_vec))
      else $error("more than one slot holds the same destination");

   // an add grows the table by exactly one
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.add_commit |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
      else $error("add did not append one route");

   // a delete shrinks the table by exactly one
   a_del_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctl.del_commit |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
      else $error("delete did not remove one route");

   // a result appears only after the execute cycle
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result without an executed request");

endmodule

@@ test/ordered_route_table_lookup_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ordered_route_table_lookup: route requests against a shadow table.
// Depends on orr_pkg and the ordered_route_table_lookup RTL.
module ordered_route_table_lookup_tb;
   import orr_pkg::*;

   localparam int ROUTE_SLOTS = TABLE_ENTRIES_DEF;
   localparam int POOL_SIZE   = 24;
   localparam int RANDOM_REQS = 2000;

   typedef struct {
      stat_type     status;
      logic [31:0]  hop;
      logic [3:0]   iface;
   } route_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = 2'd0;
   logic [31:0] req_dest_addr = 32'd0;
   logic [31:0] req_net_mask = 32'd0;
   logic [31:0] req_gateway_addr = 32'd0;
   logic        req_host_flag = 1'b0;
   logic        req_up_flag = 1'b0;
   logic        req_via_gateway_flag = 1'b0;
   logic [3:0]  req_iface_id = 4'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_next_hop;
   logic [3:0]  rsp_out_iface;

   // shadow route table, kept in insertion order
   entry_type   route_tbl [ROUTE_SLOTS];
   int          route_count = 0;

   req_type          route_reqs [$];
   route_answer_type pending_answers [$];
   req_type     cur_req;
   int          total_reqs = 0;
   int          accepted_count = 0;
   int          sent_count = 0;
   int          mismatches = 0;
   bit          req_taken = 1'b0;
   int          send_gap = 0;
   int          rsp_stall = 0;
   int          rx_cycle = 0;
   logic        hold_rsp = 1'b0;

   logic [31:0] pool_dest [POOL_SIZE];
   logic [31:0] pool_mask [POOL_SIZE];

   ordered_route_table_lookup #(.TABLE_ENTRIES(ROUTE_SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_dest_addr(req_dest_addr),
      .req_net_mask(req_net_mask), .req_gateway_addr(req_gateway_addr),
      .req_host_flag(req_host_flag), .req_up_flag(req_up_flag),
      .req_via_gateway_flag(req_via_gateway_flag), .req_iface_id(req_iface_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_next_hop(rsp_next_hop),
      .rsp_out_iface(rsp_out_iface)
   );

   always #1 clock = ~clock;

   function automatic int find_route(logic [31:0] dest);
      for (int i = 0; i < route_count; i++)
         if (route_tbl[i].dest == dest)
            return i;
      return -1;
   endfunction

   // Applies one request to the shadow table and returns the answer it must produce.
   function automatic route_answer_type apply_route_request(req_type rq);
      route_answer_type ans;
      int          k;
      bit          hit;
      logic [31:0] hop;
      logic [3:0]  oif;
      ans.status = STAT_OK;
      ans.hop    = 32'd0;
      ans.iface  = 4'd0;
      hit = 1'b0;
      hop = 32'd0;
      oif = 4'd0;
      case (rq.cmd)
         CMD_ADD: begin
            // duplicate check comes before the full check
            if (find_route(rq.ent.dest) >= 0)
               ans.status = STAT_EXISTS;
            else if (route_count >= ROUTE_SLOTS)
               ans.status = STAT_FULL;
            else begin
               route_tbl[route_count] = rq.ent;
               route_count++;
            end
         end
         CMD_DEL: begin
            k = find_route(rq.ent.dest);
            if (k < 0)
               ans.status = STAT_NOT_FOUND;
            else begin
               for (int i = k; i + 1 < route_count; i++)
                  route_tbl[i] = route_tbl[i + 1];
               route_count--;
            end
         end
         CMD_LOOKUP: begin
            for (int i = 0; i < route_count && !hit; i++) begin
               if (route_tbl[i].host) begin
                  if (route_tbl[i].dest == rq.ent.dest) begin
                     hop = route_tbl[i].gateway;
                     hit = 1'b1;
                  end
               end else if ((rq.ent.dest & route_tbl[i].mask) == route_tbl[i].dest) begin
                  hop = rq.ent.dest;
                  hit = 1'b1;
               end else if (route_tbl[i].dest == 32'd0) begin
                  // default route
                  hop = route_tbl[i].gateway;
                  hit = 1'b1;
               end
               if (hit)
                  oif = route_tbl[i].iface;
            end
            // an interface out of range counts as no route
            if (hit && oif < IFACE_COUNT) begin
               ans.hop   = hop;
               ans.iface = oif;
            end else
               ans.status = STAT_NO_ROUTE;
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic req_type make_req(cmd_type c, logic [31:0] d, logic [31:0] m,
                                        logic [31:0] g, int h, int u, int v,
                                        logic [3:0] ifc);
      req_type rq;
      rq.cmd         = c;
      rq.ent.dest    = d;
      rq.ent.mask    = m;
      rq.ent.gateway = g;
      rq.ent.host    = (h != 0);
      rq.ent.up      = (u != 0);
      rq.ent.via     = (v != 0);
      rq.ent.iface   = ifc;
      return rq;
   endfunction

   // mostly short gaps, a few long ones; none at all during quiet phases
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type random_route_req();
      req_type     rq;
      int          r;
      int          p;
      logic [31:0] d;
      r = $urandom_range(0, 99);
      p = $urandom_range(0, POOL_SIZE - 1);
      rq = make_req(CMD_LOOKUP, $urandom, $urandom, $urandom,
                    int'($urandom_range(0, 99) < 25),
                    $urandom_range(0, 1), $urandom_range(0, 1),
                    4'($urandom_range(0, 15)));
      if (r < 36) begin
         rq.cmd = CMD_ADD;
         if ($urandom_range(0, 9) != 0)
            rq.ent.dest = pool_dest[p];
         if ($urandom_range(0, 9) != 0)
            rq.ent.mask = pool_mask[p];
      end else if (r < 60) begin
         rq.cmd = CMD_DEL;
         if ($urandom_range(0, 6) != 0)
            rq.ent.dest = pool_dest[p];
      end else if (r < 95) begin
         r = $urandom_range(0, 99);
         d = $urandom;
         if (r < 70)
            rq.ent.dest = pool_dest[p] | (d & ~pool_mask[p]);
         else if (r < 85)
            rq.ent.dest = pool_dest[p];
      end else
         rq.cmd = CMD_RSVD;
      return rq;
   endfunction

   // Request driver: presents the next queued request at the falling edge.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (route_reqs.size() > 0) begin
            cur_req = route_reqs.pop_front();
            req_valid            <= 1'b1;
            req_command          <= cur_req.cmd;
            req_dest_addr        <= cur_req.ent.dest;
            req_net_mask         <= cur_req.ent.mask;
            req_gateway_addr     <= cur_req.ent.gateway;
            req_host_flag        <= cur_req.ent.host;
            req_up_flag          <= cur_req.ent.up;
            req_via_gateway_flag <= cur_req.ent.via;
            req_iface_id         <= cur_req.ent.iface;
            send_gap = pick_gap((sent_count / 250) % 3 == 1);
            sent_count++;
         end else
            req_valid <= 1'b0;
      end
   end

   // Response side: random stalls, a long hold-off forced from its own process.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_rsp)
            rsp_ready <= 1'b0;
         else if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = pick_gap((rx_cycle / 600) % 3 == 2);
         end
         rx_cycle++;
      end
   end

   initial begin
      wait (accepted_count >= 300);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (250) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Monitor: predicts on each accepted request, checks each accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_answers.push_back(apply_route_request(cur_req));
            accepted_count++;
         end
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected route response: status %0d hop %h iface %0d",
                           rsp_status, rsp_next_hop, rsp_out_iface);
            end else if (rsp_status !== pending_answers[0].status ||
                         rsp_next_hop !== pending_answers[0].hop ||
                         rsp_out_iface !== pending_answers[0].iface) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"route response mismatch: exp status %0d hop %h iface %0d,",
                            " got status %0d hop %h iface %0d"},
                           pending_answers[0].status, pending_answers[0].hop,
                           pending_answers[0].iface, rsp_status, rsp_next_hop,
                           rsp_out_iface);
               void'(pending_answers.pop_front());
            end else
               void'(pending_answers.pop_front());
         end
      end
   end

   initial begin
      int          len;
      int          counted;
      req_type     rq;
      logic [31:0] net24;

      // destination pool: prefixes of random length, slot 0 is the default route
      for (int i = 0; i < POOL_SIZE; i++) begin
         len = $urandom_range(0, 32);
         pool_mask[i] = 32'hFFFF_FFFF << (32 - len);
         pool_dest[i] = $urandom & pool_mask[i];
      end
      pool_dest[0] = 32'd0;

      net24 = 32'hC0A8_0100;
      // empty table, unused command
      route_reqs.push_back(make_req(CMD_LOOKUP, 32'd0, 32'd0, 32'd0, 0, 0, 0, 4'd0));
      route_reqs.push_back(make_req(CMD_DEL, 32'd0, 32'd0, 32'd0, 0, 0, 0, 4'd0));
      route_reqs.push_back(make_req(CMD_RSVD, '1, '1, '1, 1, 1, 1, 4'hF));
      // host route, net route, duplicate
      route_reqs.push_back(make_req(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0A00_0001,
                                    1, 1, 1, 4'hF));
      route_reqs.push_back(make_req(CMD_ADD, net24, 32'hFFFF_FF00, 32'hFFFF_FFFF,
                                    0, 1, 0, 4'd1));
      route_reqs.push_back(make_req(CMD_ADD, net24, 32'h0, 32'h0, 1, 0, 1, 4'd2));
      route_reqs.push_back(make_req(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, 0, 0, 0, 4'd0));
      route_reqs.push_back(make_req(CMD_LOOKUP, 32'hC0A8_014D, '0, '0, 0, 0, 0, 4'd0));
      route_reqs.push_back(make_req(CMD_LOOKUP, 32'h0A00_0005, '0, '0, 0, 0, 0, 4'd0));
      // default route catches what the others miss
      route_reqs.push_back(make_req(CMD_ADD, 32'd0, 32'hFFFF_FFFF, 32'hC0A8_0101,
                                    0, 1, 1, 4'd0));
      route_reqs.push_back(make_req(CMD_LOOKUP, 32'h0A00_0005, '0, '0, 0, 0, 0, 4'd0));
      // delete from the middle, then lookup falls through to default
      route_reqs.push_back(make_req(CMD_DEL, net24, '0, '0, 0, 0, 0, 4'd0));
      route_reqs.push_back(make_req(CMD_LOOKUP, 32'hC0A8_014D, '0, '0, 0, 0, 0, 4'd0));
      route_reqs.push_back(make_req(CMD_DEL, 32'hDEAD_BEEF, '0, '0, 0, 0, 0, 4'd0));
      // fill the table, then overflow it
      for (int i = 0; i < ROUTE_SLOTS - 2; i++)
         route_reqs.push_back(make_req(CMD_ADD, {8'd10, i[7:0], 16'h0}, 32'hFFFF_0000,
                                       $urandom, int'((i % 3) == 0), int'(i[0]),
                                       int'(i[1]), i[3:0]));
      route_reqs.push_back(make_req(CMD_ADD, 32'h0B00_0000, '1, '1, 0, 0, 0, 4'd3));
      route_reqs.push_back(make_req(CMD_ADD, 32'hFFFF_FFFF, '1, '1, 0, 0, 0, 4'd3));
      // remove the head entry, the host lookup now lands on the default route
      route_reqs.push_back(make_req(CMD_DEL, 32'hFFFF_FFFF, '0, '0, 0, 0, 0, 4'd0));
      route_reqs.push_back(make_req(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, 0, 0, 0, 4'd0));

      // random traffic over the pool; reserved commands are extra
      counted = 0;
      while (counted < RANDOM_REQS) begin
         rq = random_route_req();
         route_reqs.push_back(rq);
         if (rq.cmd != CMD_RSVD)
            counted++;
      end
      total_reqs = route_reqs.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted_count == total_reqs && pending_answers.size() == 0);
      repeat (10) @(posedge clock);
      if (pending_answers.size() != 0)
         mismatches++;
      if (mismatches == 0)
         $display("[ordered_route_table_lookup] OK");
      else
         $display("[ordered_route_table_lookup] ERROR");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("[ordered_route_table_lookup] ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/orr_pkg.sv
rtl/orr_cell.sv
rtl/orr_pick.sv
rtl/ordered_route_table_lookup.sv
test/ordered_route_table_lookup_tb.sv
